>>> rtl/unbiased_random_range_reducer_macros.svh
// Assertion macros for the unbiased random range reducer checker.
`ifndef UNBIASED_RANDOM_RANGE_REDUCER_MACROS_SVH
`define UNBIASED_RANDOM_RANGE_REDUCER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define URR_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("urr assertion failed");

// Next-cycle implication, disabled in reset.
`define URR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("urr assertion failed");

`endif

>>> rtl/urr_pkg.sv
// Shared constants and types of the unbiased random range reducer.
package urr_pkg;

    localparam int unsigned DATA_W  = 64;
    localparam int unsigned BYTES_W = 4;
    localparam int unsigned RETRY_W = 6;
    localparam int unsigned CNT_W   = $clog2(DATA_W);

    localparam logic [RETRY_W-1:0] MAX_ATTEMPTS = RETRY_W'(50);

    localparam logic [DATA_W-1:0] ALL32 = 64'h0000_0000_FFFF_FFFF;
    localparam logic [DATA_W-1:0] ALL64 = 64'hFFFF_FFFF_FFFF_FFFF;

    localparam logic CFG_RANGE_MIN = 1'b0;
    localparam logic CFG_RANGE_MAX = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_GEN_ERR = 2'd1;
    localparam logic [1:0] ST_LIMIT   = 2'd2;

    typedef struct packed {
        logic              complete;
        logic [DATA_W-1:0] draw;
    } t_gather_out;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } t_rem_req;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] rem;
    } t_rem_out;

endpackage

>>> rtl/urr_gather.sv
// Byte gatherer that packs generator chunks into one draw.
module urr_gather
    import urr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic               i_wide,
    input  logic [DATA_W-1:0]  i_chunk,
    input  logic [BYTES_W-1:0] i_bytes,
    input  logic               i_error,
    output t_gather_out        o_stat
);

    logic [DATA_W-1:0] r_acc;
    logic [2:0]        r_bytes;

    logic [DATA_W-1:0] chunk_m;
    logic [DATA_W-1:0] merged;
    logic [4:0]        total;
    logic [4:0]        need;

    always_comb begin
        chunk_m = i_wide ? i_chunk : (i_chunk & ALL32);
        merged  = r_acc | (chunk_m << {r_bytes, 3'b000});
        total   = {2'b00, r_bytes} + {1'b0, i_bytes};
        need    = i_wide ? 5'd8 : 5'd4;
        o_stat.complete = (total >= need);
        o_stat.draw     = i_wide ? merged : (merged & ALL32);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_bytes <= '0;
        end else if (i_accept) begin
            if (i_error || o_stat.complete) begin
                r_acc   <= '0;
                r_bytes <= '0;
            end else begin
                r_acc   <= merged;
                r_bytes <= total[2:0];
            end
        end
    end

endmodule

>>> rtl/urr_rem.sv
// Bit-serial restoring remainder unit, one dividend bit per cycle.
module urr_rem
    import urr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_rem_req i_req,
    output t_rem_out o_res
);

    logic [DATA_W-1:0] r_dvd;
    logic [DATA_W-1:0] r_div;
    logic [DATA_W-1:0] r_rem;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_run;
    logic              r_done;

    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   diff;
    logic [DATA_W-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_dvd[DATA_W-1]};
        diff  = trial - {1'b0, r_div};
        n_rem = diff[DATA_W] ? trial[DATA_W-1:0] : diff[DATA_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DATA_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.dividend;
            r_div <= i_req.divisor;
            r_rem <= '0;
        end else if (r_run) begin
            r_dvd <= {r_dvd[DATA_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_res.done = r_done;
    assign o_res.rem  = r_rem;

endmodule

>>> rtl/unbiased_random_range_reducer.sv
// Top level of the unbiased random range reducer.
//
//   port group   dir  tdata fields (low bit up)                 tuser
//   s_axis       in   random_chunk[63:0], chunk_bytes[67:64]    gen_error
//   m_axis       out  value[63:0]                               status[1:0]
//   i_cfg_*      in   range_min (idx 0), range_max (idx 1)      -
//
// A chunk that does not finish a draw leaves the input ready. A finished
// draw passes through S_DIV, S_CHK and S_PUSH before its word shows, and
// a generator error goes straight to S_PUSH; the 64-step serial remainder
// loop sets the draw latency, and a rejected draw reopens the input from
// S_CHK. Reset is synchronous and clears the gatherer, retry count and
// output valid. One result word waits in the output register while the
// next chunk is taken; a second result holds until that word leaves.
module unbiased_random_range_reducer
    import urr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [71:0]       s_axis_tdata,  // random_chunk, chunk_bytes, pad
    input  logic              s_axis_tuser,  // gen_error
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [DATA_W-1:0] m_axis_tdata,  // value
    output logic [1:0]        m_axis_tuser,  // status
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [DATA_W-1:0] i_cfg_wdata
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_CHK  = 4'b0100,
        S_PUSH = 4'b1000
    } t_state;

    t_state            r_state;
    logic [DATA_W-1:0] r_range_min;
    logic [DATA_W-1:0] r_range_max;
    logic [DATA_W-1:0] r_span;
    logic [DATA_W-1:0] r_draw;
    logic [RETRY_W-1:0] r_retry;
    logic [DATA_W-1:0] r_res;
    logic [1:0]        r_stat;
    logic              r_ovalid;
    logic [DATA_W-1:0] r_odata;
    logic [1:0]        r_ouser;

    logic              accept;
    logic              wide;
    logic [DATA_W-1:0] all;
    logic [DATA_W-1:0] n_mod;
    logic              full;
    logic              pow2;
    logic              reject;
    logic [DATA_W-1:0] res;
    logic              push_load;

    t_gather_out       gat;
    t_rem_req          req_draw;
    t_rem_req          req_all;
    t_rem_out          rem_draw;
    t_rem_out          rem_all;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);

    always_comb begin
        wide   = |r_span[DATA_W-1:32];
        all    = wide ? ALL64 : ALL32;
        n_mod  = r_span + DATA_W'(1);
        full   = (r_span == all);
        pow2   = ((n_mod & r_span) == '0);
        reject = (r_draw >= (all - rem_all.rem));
        if (full) begin
            res = r_draw;
        end else if (pow2) begin
            res = r_draw & r_span;
        end else begin
            res = rem_draw.rem;
        end
    end

    urr_gather u_gather (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_wide   (wide),
        .i_chunk  (s_axis_tdata[DATA_W-1:0]),
        .i_bytes  (s_axis_tdata[DATA_W+BYTES_W-1:DATA_W]),
        .i_error  (s_axis_tuser),
        .o_stat   (gat)
    );

    always_comb begin
        req_draw.start    = accept && !s_axis_tuser && gat.complete;
        req_draw.dividend = gat.draw;
        req_draw.divisor  = n_mod;
        req_all.start     = req_draw.start;
        req_all.dividend  = all;
        req_all.divisor   = n_mod;
    end

    urr_rem u_rem_draw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_draw),
        .o_res   (rem_draw)
    );

    urr_rem u_rem_all (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_all),
        .o_res   (rem_all)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_min <= '0;
            r_range_max <= '0;
            r_span      <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RANGE_MIN: begin
                    r_range_min <= i_cfg_wdata;
                    r_span      <= r_range_max - i_cfg_wdata;
                end
                CFG_RANGE_MAX: begin
                    r_range_max <= i_cfg_wdata;
                    r_span      <= i_cfg_wdata - r_range_min;
                end
                default: begin
                    r_span <= r_span;
                end
            endcase
        end
    end

    assign push_load = (r_state == S_PUSH) && (!r_ovalid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_retry <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (s_axis_tuser) begin
                            r_retry <= '0;
                            r_state <= S_PUSH;
                        end else if (gat.complete) begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (rem_draw.done) begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (!full && !pow2 && reject) begin
                        if (r_retry >= MAX_ATTEMPTS) begin
                            r_retry <= '0;
                            r_state <= S_PUSH;
                        end else begin
                            r_retry <= r_retry + RETRY_W'(1);
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_retry <= '0;
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (push_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_draw.start) begin
            r_draw <= gat.draw;
        end
        if ((r_state == S_IDLE) && accept && s_axis_tuser) begin
            r_res  <= r_range_min;
            r_stat <= ST_GEN_ERR;
        end else if (r_state == S_CHK) begin
            if (!full && !pow2 && reject) begin
                r_res  <= r_range_min;
                r_stat <= ST_LIMIT;
            end else begin
                r_res  <= res + r_range_min;
                r_stat <= ST_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (push_load) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_load) begin
            r_odata <= r_res;
            r_ouser <= r_stat;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

endmodule

>>> rtl/urr_checker.sv
// Port-level checker for the unbiased random range reducer, bound to the top.
`include "unbiased_random_range_reducer_macros.svh"

module urr_checker
    import urr_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic              s_axis_tuser,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [DATA_W-1:0] m_axis_tdata,
    input logic [1:0]        m_axis_tuser
);

    `URR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    `URR_ASSERT_SAME(a_status_legal, i_clk, i_rst_n, m_axis_tvalid, (m_axis_tuser == ST_OK) || (m_axis_tuser == ST_GEN_ERR) || (m_axis_tuser == ST_LIMIT))

    `URR_ASSERT_NEXT(a_err_busy, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && s_axis_tuser, !s_axis_tready)

    `URR_ASSERT_SAME(a_push_idle, i_clk, i_rst_n, $rose(m_axis_tvalid), s_axis_tready)

endmodule

bind unbiased_random_range_reducer urr_checker u_urr_checker (.*);

>>> bench/unbiased_random_range_reducer_test.sv
// Self-checking stream testbench for the unbiased random range reducer.
`timescale 1ns / 100ps

module unbiased_random_range_reducer_test
    import urr_pkg::*;
();

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_CYCLES   = 1500;
    localparam int PHASE_ITEMS   = 72;

    typedef struct packed {
        logic              err;
        logic [3:0]        nbytes;
        logic [DATA_W-1:0] chunk;
    } t_chunk_word;

    typedef struct packed {
        logic [1:0]        status;
        logic [DATA_W-1:0] value;
    } t_outcome;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [71:0]       s_axis_tdata  = '0;
    logic              s_axis_tuser  = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [DATA_W-1:0] m_axis_tdata;
    logic [1:0]        m_axis_tuser;
    logic              i_cfg_we      = 1'b0;
    logic              i_cfg_idx     = CFG_RANGE_MIN;
    logic [DATA_W-1:0] i_cfg_wdata   = '0;

    // predictor state and register copies
    logic [DATA_W-1:0] range_min  = '0;
    logic [DATA_W-1:0] range_max  = '0;
    logic [DATA_W-1:0] draw_acc   = '0;
    logic [3:0]        bytes_held = '0;
    logic [5:0]        rejections = '0;

    t_chunk_word pending_chunks[$];
    t_outcome    predicted_outcomes[$];
    t_chunk_word word_on_bus;

    int chunks_queued   = 0;
    int chunks_accepted = 0;
    int results_seen    = 0;
    int gen_errors_seen = 0;
    int limits_seen     = 0;
    int settings_used   = 0;
    int failures        = 0;
    int cycle_count     = 0;
    int send_gap        = 0;
    int recv_gap        = 0;
    int hold_left       = 0;
    int stall_requests  = 0;
    int stalls_served   = 0;
    bit send_idle_on    = 1'b1;
    bit recv_idle_on    = 1'b1;

    unbiased_random_range_reducer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // random_chunk[63:0], chunk_bytes[67:64], pad
        .s_axis_tuser  (s_axis_tuser),   // gen_error
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // value[63:0]
        .m_axis_tuser  (m_axis_tuser),   // status[1:0]
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic restart_draw();
        draw_acc   = '0;
        bytes_held = '0;
        rejections = '0;
    endtask

    task automatic predict_chunk(input t_chunk_word w);
        logic [DATA_W-1:0] span, all_ones, piece, draw, modulus, ceiling, reduced;
        logic              wide;
        logic [4:0]        total, need;
        span     = range_max - range_min;
        wide     = span > ALL32;
        all_ones = wide ? ALL64 : ALL32;
        need     = wide ? 5'd8 : 5'd4;
        piece    = wide ? w.chunk : (w.chunk & ALL32);
        draw_acc = draw_acc | (piece << {bytes_held[2:0], 3'b000});
        total    = {1'b0, bytes_held} + {1'b0, w.nbytes};
        if (w.err) begin
            restart_draw();
            predicted_outcomes.push_back('{status: ST_GEN_ERR, value: range_min});
            return;
        end
        if (total < need) begin
            bytes_held = total[3:0];
            return;
        end
        draw       = draw_acc & all_ones;
        draw_acc   = '0;
        bytes_held = '0;
        modulus    = span + 64'd1;
        if (span == all_ones) begin
            reduced = draw;
        end else if ((modulus & (modulus - 64'd1)) == '0) begin
            reduced = draw & span;
        end else begin
            ceiling = all_ones - (all_ones % modulus) - 64'd1;
            if (draw > ceiling) begin
                if (rejections >= MAX_ATTEMPTS) begin
                    restart_draw();
                    predicted_outcomes.push_back('{status: ST_LIMIT, value: range_min});
                end else begin
                    rejections = rejections + 6'd1;
                end
                return;
            end
            reduced = draw % modulus;
        end
        rejections = '0;
        predicted_outcomes.push_back('{status: ST_OK, value: reduced + range_min});
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_chunk(word_on_bus);
                chunks_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_chunks.size() > 0) begin
                    word_on_bus = pending_chunks.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {4'b0000, word_on_bus.nbytes, word_on_bus.chunk};
                    s_axis_tuser  <= word_on_bus.err;
                    if (send_idle_on && $urandom_range(0, 5) == 0)
                        send_gap = $urandom_range(1, 7);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (predicted_outcomes.size() == 0) begin
                    $error("unexpected word: value %h status %0d", m_axis_tdata, m_axis_tuser);
                    failures++;
                end else begin
                    want = predicted_outcomes.pop_front();
                    if (m_axis_tdata !== want.value) begin
                        $error("value: expected %h, got %h", want.value, m_axis_tdata);
                        failures++;
                    end
                    if (m_axis_tuser !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
                        failures++;
                    end
                    results_seen++;
                    if (want.status == ST_GEN_ERR) gen_errors_seen++;
                    if (want.status == ST_LIMIT) limits_seen++;
                end
            end
            if (stalls_served != stall_requests) begin
                stalls_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_axis_tready <= 1'b0;
            end else if (recv_idle_on && $urandom_range(0, 5) == 0) begin
                recv_gap = $urandom_range(0, 6);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic queue_chunk(input logic [DATA_W-1:0] chunk, input int nbytes, input bit err);
        pending_chunks.push_back('{err: err, nbytes: nbytes[3:0], chunk: chunk});
        chunks_queued++;
    endtask

    function automatic logic [DATA_W-1:0] random_word();
        case ($urandom_range(0, 15))
            0, 1:    return ALL64;
            2:       return '0;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // hold until every word is taken and every result is back, then let the block go quiet
    task automatic finish_phase();
        while (chunks_accepted != chunks_queued || predicted_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_range(input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_RANGE_MIN;
        i_cfg_wdata <= lo;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_RANGE_MAX;
        i_cfg_wdata <= hi;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        range_min = lo;
        range_max = hi;
        settings_used++;
    endtask

    task automatic queue_random_phase(input int items);
        int target, left, take;
        target = chunks_queued + items;
        while (chunks_queued < target) begin
            if ($urandom_range(0, 6) == 0) begin
                queue_chunk(random_word(), $urandom_range(0, 15), $urandom_range(0, 3) == 0);
            end else begin
                left = ((range_max - range_min) > ALL32) ? 8 : 4;
                while (left > 0) begin
                    take = ($urandom_range(0, 2) == 0) ? left : $urandom_range(1, left);
                    queue_chunk(random_word(), take, $urandom_range(0, 40) == 0);
                    left -= take;
                end
            end
        end
    endtask

    initial begin
        logic [DATA_W-1:0] lo, span;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset registers: zero span, every draw reduces to min
        write_range(64'd0, 64'd0);
        queue_chunk(ALL64, 4, 1'b0);
        queue_chunk(64'h00FF_00FF_00FF_00FF, 0, 1'b0);
        queue_chunk(64'h1234_5678_9ABC_DEF0, 15, 1'b0);
        queue_chunk(ALL64, 2, 1'b0);
        queue_chunk(ALL64, 8, 1'b1);
        finish_phase();

        // full wide span, returned raw
        write_range(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
        queue_chunk(ALL64, 8, 1'b0);
        queue_chunk(64'hDEAD_BEEF_1122_3344, 4, 1'b0);
        queue_chunk(64'h5566_7788_AABB_CCDD, 4, 1'b0);
        queue_chunk(64'd0, 8, 1'b0);
        finish_phase();

        // full narrow span; leave three bytes gathered across the next write
        write_range(64'd0, ALL32);
        queue_chunk(ALL64, 4, 1'b0);
        queue_chunk(64'hCAFE_F00D_0000_ABCD, 2, 1'b0);
        queue_chunk(64'h0000_0000_1357_2468, 2, 1'b0);
        queue_chunk(64'h0102_0304_0506_0708, 3, 1'b0);
        finish_phase();

        // min above max wraps to a span of one
        write_range(64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
        queue_chunk(64'hFFFF_FFFF_FFFF_FF01, 5, 1'b0);
        queue_chunk(ALL64, 4, 1'b0);
        finish_phase();

        // nearly half the narrow draws reject: drive the attempt limit, then the ceiling
        write_range(64'd5, 64'd5 + 64'h8000_0000);
        repeat (51) queue_chunk(ALL64, 4, 1'b0);
        queue_chunk(64'h8000_0000, 4, 1'b0);
        queue_chunk(64'h8000_0001, 4, 1'b0);
        queue_chunk(64'd0, 4, 1'b0);
        finish_phase();

        write_range(-64'sd100, 64'sd100);
        stall_requests++;
        queue_random_phase(PHASE_ITEMS);
        finish_phase();

        write_range(-64'sd1000, 64'h0000_0100_0000_0000);
        queue_random_phase(PHASE_ITEMS);
        finish_phase();

        write_range(64'd0, 64'h0000_FFFF_FFFF_FFFF);
        queue_random_phase(PHASE_ITEMS);
        finish_phase();

        write_range(64'd0, 64'h8000_0000_0000_0000);
        queue_random_phase(PHASE_ITEMS);
        finish_phase();

        write_range(64'd5, 64'd5 + 64'h8000_0000);
        queue_random_phase(PHASE_ITEMS);
        finish_phase();

        write_range(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
        queue_random_phase(PHASE_ITEMS);
        finish_phase();

        repeat (2) begin
            lo = {$urandom, $urandom};
            case ($urandom_range(0, 2))
                0:       span = 64'($urandom_range(1, 1000));
                1:       span = {32'd0, $urandom};
                default: span = {$urandom, $urandom};
            endcase
            write_range(lo, lo + span);
            queue_random_phase(PHASE_ITEMS / 2);
            finish_phase();
        end

        // last stretch runs at full rate on both sides
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        write_range({$urandom, $urandom}, {$urandom, $urandom});
        queue_random_phase(PHASE_ITEMS);
        finish_phase();

        $display("Covered %0d chunk words over %0d range settings, narrow and wide paths.",
                 chunks_accepted, settings_used);
        $display("Checked %0d results: %0d generator errors, %0d attempt-limit exits.",
                 results_seen, gen_errors_seen, limits_seen);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
